>>> design/dpsh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsh_pkg
// Shared types, constants and state encodings of the double polynomial
// substring hash block.
// ----------------------------------------------------------------------------
package dpsh_pkg;

    localparam int MAX_LEN   = 4096;
    localparam int ADDR_W    = $clog2(MAX_LEN);
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int WORD_W    = 31;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 3;

    typedef logic [WORD_W-1:0] t_word;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ONE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_TWO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_BASE_ONE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_BASE_TWO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_ONE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_TWO  = 3'd5;

    localparam t_word RST_BASE_ONE    = 31'd999999937;
    localparam t_word RST_BASE_TWO    = 31'd999999929;
    localparam t_word RST_INV_BASE    = 31'd1;
    localparam t_word RST_MODULUS_ONE = 31'd1000000007;
    localparam t_word RST_MODULUS_TWO = 31'd1000000009;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // byte value of the character just below 'a'
    localparam logic [7:0] CHAR_OFFSET = 8'd96;

    // append micro-steps
    localparam logic [STEP_W-1:0] ST_CHAR_RAW = 3'd0;
    localparam logic [STEP_W-1:0] ST_CHAR_VAL = 3'd1;
    localparam logic [STEP_W-1:0] ST_TERM     = 3'd2;
    localparam logic [STEP_W-1:0] ST_PREFIX   = 3'd3;
    localparam logic [STEP_W-1:0] ST_INVPOW   = 3'd4;
    localparam logic [STEP_W-1:0] ST_POWER    = 3'd5;
    localparam logic [STEP_W-1:0] ST_INVRUN   = 3'd6;
    // query micro-steps
    localparam logic [STEP_W-1:0] ST_LOW      = 3'd0;
    localparam logic [STEP_W-1:0] ST_DIFF     = 3'd1;
    localparam logic [STEP_W-1:0] ST_HASH     = 3'd2;

    typedef enum logic [1:0] {TS_IDLE, TS_RUN, TS_OUT} t_top_state;
    typedef enum logic [2:0] {LS_IDLE, LS_RD1, LS_RD2, LS_ISSUE, LS_WAIT} t_lane_state;
    typedef enum logic [1:0] {MS_IDLE, MS_RED, MS_MUL} t_mm_state;

    typedef struct packed {
        logic              start;
        logic              query;
        logic              restart;
        logic [7:0]        char_byte;
        logic [ADDR_W-1:0] pos;
        logic [ADDR_W-1:0] left_pos;
        logic [ADDR_W-1:0] right_pos;
    } t_lane_cmd;

    typedef struct packed {
        logic  done;
        t_word hash;
    } t_lane_rsp;

endpackage

>>> design/dpsh_mulmod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsh_mulmod
// Bit-serial modular multiplier: reduces y, then forms x*y mod m one bit of
// x per cycle (MSB first). A zero modulus yields zero.
// ----------------------------------------------------------------------------
module dpsh_mulmod (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [31:0]         i_x,
    input  dpsh_pkg::t_word     i_y,
    input  dpsh_pkg::t_word     i_modulus,
    output logic                o_done,
    output dpsh_pkg::t_word     o_res
);

    dpsh_pkg::t_mm_state r_state, n_state;
    logic [4:0]          r_cnt;
    logic [31:0]         r_x;
    dpsh_pkg::t_word     r_y, r_yr, r_acc, n_acc;
    logic                r_done;
    logic [31:0]         red_s, dbl_s, add_s, mod32;

    assign mod32 = {1'b0, i_modulus};

    always_comb begin
        red_s = {r_acc, r_y[r_cnt]};
        if (red_s >= mod32) begin
            red_s = red_s - mod32;
        end
        dbl_s = {r_acc, 1'b0};
        if (dbl_s >= mod32) begin
            dbl_s = dbl_s - mod32;
        end
        add_s = dbl_s + (r_x[r_cnt] ? {1'b0, r_yr} : 32'd0);
        if (add_s >= mod32) begin
            add_s = add_s - mod32;
        end
    end

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        case (r_state)
            dpsh_pkg::MS_IDLE: begin
                if (i_start) begin
                    n_state = dpsh_pkg::MS_RED;
                    n_acc   = '0;
                end
            end
            dpsh_pkg::MS_RED: begin
                n_acc = red_s[30:0];
                if (r_cnt == 5'd0) begin
                    n_state = dpsh_pkg::MS_MUL;
                    n_acc   = '0;
                end
            end
            dpsh_pkg::MS_MUL: begin
                n_acc = add_s[30:0];
                if (r_cnt == 5'd0) begin
                    n_state = dpsh_pkg::MS_IDLE;
                end
            end
            default: n_state = dpsh_pkg::MS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dpsh_pkg::MS_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == dpsh_pkg::MS_MUL) && (r_cnt == 5'd0);
            case (r_state)
                dpsh_pkg::MS_IDLE: r_cnt <= 5'd30;
                dpsh_pkg::MS_RED:  r_cnt <= (r_cnt == 5'd0) ? 5'd31 : r_cnt - 5'd1;
                dpsh_pkg::MS_MUL:  r_cnt <= r_cnt - 5'd1;
                default:           r_cnt <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (r_state == dpsh_pkg::MS_IDLE && i_start) begin
            r_x <= i_x;
            r_y <= i_y;
        end
        // hold the reduced multiplicand for the multiply pass
        if (r_state == dpsh_pkg::MS_RED && r_cnt == 5'd0) begin
            r_yr <= red_s[30:0];
        end
    end

    assign o_done = r_done;
    assign o_res  = (i_modulus == '0) ? '0 : r_acc;

endmodule

>>> design/dpsh_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsh_lane
// One modulus of the double hash: prefix and inverse-power memories, running
// powers, and a micro-step sequencer around a serial modular multiplier.
// ----------------------------------------------------------------------------
module dpsh_lane (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dpsh_pkg::t_lane_cmd   i_cmd,
    input  dpsh_pkg::t_word       i_base,
    input  dpsh_pkg::t_word       i_inv_base,
    input  dpsh_pkg::t_word       i_modulus,
    output dpsh_pkg::t_lane_rsp   o_rsp
);

    dpsh_pkg::t_lane_state               r_state, n_state;
    logic [dpsh_pkg::STEP_W-1:0]         r_step;
    logic                                r_query, r_done;
    logic [7:0]                          r_byte;
    logic [dpsh_pkg::ADDR_W-1:0]         r_pos, r_left, r_right;
    dpsh_pkg::t_word                     r_prev, r_ip, r_hi, r_t, r_pr, r_inv, r_hash;
    dpsh_pkg::t_word                     r_pf_q, r_iv_q;
    dpsh_pkg::t_word                     pf_mem [dpsh_pkg::MAX_LEN];
    dpsh_pkg::t_word                     iv_mem [dpsh_pkg::MAX_LEN];
    logic [dpsh_pkg::ADDR_W-1:0]         pf_addr;

    logic            mm_start, mm_done, last_step, char_neg;
    logic [31:0]     mm_x;
    dpsh_pkg::t_word mm_y, mm_res, prev_eff, low_eff;
    logic [7:0]      char_raw;
    logic [31:0]     mod_minus_t;

    assign char_neg    = r_byte < dpsh_pkg::CHAR_OFFSET;
    assign char_raw    = char_neg ? dpsh_pkg::CHAR_OFFSET - r_byte
                                  : r_byte - dpsh_pkg::CHAR_OFFSET;
    assign mod_minus_t = {1'b0, i_modulus} - {1'b0, r_t};
    assign prev_eff    = (r_pos == '0) ? '0 : r_prev;
    assign low_eff     = (r_left == '0) ? '0 : r_prev;
    assign last_step   = r_query ? (r_step == dpsh_pkg::ST_HASH)
                                 : (r_step == dpsh_pkg::ST_INVRUN);

    // operand selection per micro-step
    always_comb begin
        mm_x = '0;
        mm_y = 31'd1;
        if (r_query) begin
            case (r_step)
                dpsh_pkg::ST_LOW:  mm_x = {1'b0, low_eff};
                dpsh_pkg::ST_DIFF: mm_x = {1'b0, r_hi} + mod_minus_t;
                dpsh_pkg::ST_HASH: begin
                    mm_x = {1'b0, r_t};
                    mm_y = r_ip;
                end
                default: mm_x = '0;
            endcase
        end else begin
            case (r_step)
                dpsh_pkg::ST_CHAR_RAW: mm_x = {24'd0, char_raw};
                dpsh_pkg::ST_CHAR_VAL: mm_x = char_neg ? mod_minus_t : {1'b0, r_t};
                dpsh_pkg::ST_TERM: begin
                    mm_x = {1'b0, r_pr};
                    mm_y = r_t;
                end
                dpsh_pkg::ST_PREFIX:   mm_x = {1'b0, prev_eff} + {1'b0, r_t};
                dpsh_pkg::ST_INVPOW:   mm_x = {1'b0, r_inv};
                dpsh_pkg::ST_POWER: begin
                    mm_x = {1'b0, r_pr};
                    mm_y = i_base;
                end
                dpsh_pkg::ST_INVRUN: begin
                    mm_x = {1'b0, r_inv};
                    mm_y = i_inv_base;
                end
                default: mm_x = '0;
            endcase
        end
    end

    always_comb begin
        n_state  = r_state;
        mm_start = 1'b0;
        case (r_state)
            dpsh_pkg::LS_IDLE:  if (i_cmd.start) n_state = dpsh_pkg::LS_RD1;
            dpsh_pkg::LS_RD1:   n_state = dpsh_pkg::LS_RD2;
            dpsh_pkg::LS_RD2:   n_state = dpsh_pkg::LS_ISSUE;
            dpsh_pkg::LS_ISSUE: begin
                mm_start = 1'b1;
                n_state  = dpsh_pkg::LS_WAIT;
            end
            dpsh_pkg::LS_WAIT: begin
                if (mm_done) begin
                    n_state = last_step ? dpsh_pkg::LS_IDLE : dpsh_pkg::LS_ISSUE;
                end
            end
            default: n_state = dpsh_pkg::LS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dpsh_pkg::LS_IDLE;
            r_step  <= '0;
            r_done  <= 1'b0;
            r_pr    <= 31'd1;
            r_inv   <= 31'd1;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == dpsh_pkg::LS_WAIT) && mm_done && last_step;
            if (r_state == dpsh_pkg::LS_IDLE && i_cmd.start) begin
                r_step <= '0;
                if (!i_cmd.query && i_cmd.restart) begin
                    r_pr  <= 31'd1;
                    r_inv <= 31'd1;
                end
            end
            if (r_state == dpsh_pkg::LS_WAIT && mm_done) begin
                r_step <= r_step + 1'b1;
                if (!r_query && r_step == dpsh_pkg::ST_POWER) begin
                    r_pr <= mm_res;
                end
                if (!r_query && r_step == dpsh_pkg::ST_INVRUN) begin
                    r_inv <= mm_res;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == dpsh_pkg::LS_IDLE && i_cmd.start) begin
            r_query <= i_cmd.query;
            r_byte  <= i_cmd.char_byte;
            r_pos   <= i_cmd.pos;
            r_left  <= i_cmd.left_pos;
            r_right <= i_cmd.right_pos;
        end
        if (r_state == dpsh_pkg::LS_RD1) begin
            r_prev <= r_pf_q;
            r_ip   <= r_iv_q;
        end
        if (r_state == dpsh_pkg::LS_RD2) begin
            r_hi <= r_pf_q;
        end
        if (r_state == dpsh_pkg::LS_WAIT && mm_done) begin
            if (r_query && r_step == dpsh_pkg::ST_HASH) begin
                r_hash <= mm_res;
            end else begin
                r_t <= mm_res;
            end
        end
    end

    // prefix memory: the start cycle reads the entry below the low end, the
    // next cycle reads the high end of a query
    assign pf_addr = (r_state == dpsh_pkg::LS_IDLE)
                   ? (i_cmd.query ? i_cmd.left_pos - 1'b1 : i_cmd.pos - 1'b1)
                   : r_right;

    always_ff @(posedge i_clk) begin
        r_pf_q <= pf_mem[pf_addr];
        r_iv_q <= iv_mem[i_cmd.left_pos];
        if (r_state == dpsh_pkg::LS_WAIT && mm_done && !r_query) begin
            if (r_step == dpsh_pkg::ST_PREFIX) begin
                pf_mem[r_pos] <= mm_res;
            end
            if (r_step == dpsh_pkg::ST_INVPOW) begin
                iv_mem[r_pos] <= mm_res;
            end
        end
    end

    dpsh_mulmod u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mm_start),
        .i_x       (mm_x),
        .i_y       (mm_y),
        .i_modulus (i_modulus),
        .o_done    (mm_done),
        .o_res     (mm_res)
    );

    assign o_rsp.done = r_done;
    assign o_rsp.hash = r_hash;

endmodule

>>> design/double_polynomial_substring_hash.sv
`timescale 1ns / 1ps
// Each of the 7 (append) or 3 (query) modular products runs on the bit-serial
// multiplier of each lane, after the memory-read states and an issue state.
// Invalid queries and appends to a full string go straight to the output state
// without starting the lanes.
// Throughput: one item at a time. Reset (synchronous, active low) restores the
// configuration defaults, empties the string and sets the running powers to one.
// ----------------------------------------------------------------------------
// double_polynomial_substring_hash
// Builds a two-modulus polynomial hash of a string and answers substring
// hash queries from stored prefix sums and inverse powers.
// ----------------------------------------------------------------------------
module double_polynomial_substring_hash (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_opcode,
    input  logic                              i_restart,
    input  logic [7:0]                        i_char_byte,
    input  logic [dpsh_pkg::ADDR_W-1:0]       i_left_pos,
    input  logic [dpsh_pkg::ADDR_W-1:0]       i_right_pos,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [30:0]                       o_hash_first,
    output logic [30:0]                       o_hash_second,
    output logic [1:0]                        o_status,
    input  logic                              i_cfg_we,
    input  logic [dpsh_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [30:0]                       i_cfg_data
);

    dpsh_pkg::t_top_state          r_state, n_state;
    dpsh_pkg::t_word               r_base_one, r_base_two, r_inv_one, r_inv_two;
    dpsh_pkg::t_word               r_mod_one, r_mod_two;
    logic [dpsh_pkg::LEN_W-1:0]    r_len;
    logic                          r_o_valid;
    logic                          r_query;
    dpsh_pkg::t_word               r_res_h1, r_res_h2, r_o_h1, r_o_h2;
    logic [1:0]                    r_res_status, r_o_status;

    logic                          accept, is_query, full_fail, range_fail, out_free;
    logic [dpsh_pkg::ADDR_W-1:0]   app_pos;
    dpsh_pkg::t_lane_cmd           lane_cmd;
    dpsh_pkg::t_lane_rsp           rsp_one, rsp_two;

    assign o_ready    = (r_state == dpsh_pkg::TS_IDLE);
    assign accept     = i_valid && o_ready;
    assign is_query   = (i_opcode == dpsh_pkg::OP_QUERY);
    assign full_fail  = !is_query && !i_restart
                      && (r_len == dpsh_pkg::LEN_W'(dpsh_pkg::MAX_LEN));
    assign range_fail = is_query && ((i_left_pos > i_right_pos)
                      || ({1'b0, i_right_pos} >= r_len));
    assign app_pos    = i_restart ? '0 : r_len[dpsh_pkg::ADDR_W-1:0];
    assign out_free   = !r_o_valid || i_ready;

    always_comb begin
        lane_cmd.start     = accept && !full_fail && !range_fail;
        lane_cmd.query     = is_query;
        lane_cmd.restart   = i_restart;
        lane_cmd.char_byte = i_char_byte;
        lane_cmd.pos       = app_pos;
        lane_cmd.left_pos  = i_left_pos;
        lane_cmd.right_pos = i_right_pos;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dpsh_pkg::TS_IDLE: begin
                if (accept) begin
                    n_state = (full_fail || range_fail) ? dpsh_pkg::TS_OUT
                                                        : dpsh_pkg::TS_RUN;
                end
            end
            dpsh_pkg::TS_RUN: if (rsp_one.done) n_state = dpsh_pkg::TS_OUT;
            dpsh_pkg::TS_OUT: if (out_free) n_state = dpsh_pkg::TS_IDLE;
            default:          n_state = dpsh_pkg::TS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= dpsh_pkg::TS_IDLE;
            r_len      <= '0;
            r_o_valid  <= 1'b0;
            r_base_one <= dpsh_pkg::RST_BASE_ONE;
            r_base_two <= dpsh_pkg::RST_BASE_TWO;
            r_inv_one  <= dpsh_pkg::RST_INV_BASE;
            r_inv_two  <= dpsh_pkg::RST_INV_BASE;
            r_mod_one  <= dpsh_pkg::RST_MODULUS_ONE;
            r_mod_two  <= dpsh_pkg::RST_MODULUS_TWO;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    dpsh_pkg::CFG_BASE_ONE:     r_base_one <= i_cfg_data;
                    dpsh_pkg::CFG_BASE_TWO:     r_base_two <= i_cfg_data;
                    dpsh_pkg::CFG_INV_BASE_ONE: r_inv_one  <= i_cfg_data;
                    dpsh_pkg::CFG_INV_BASE_TWO: r_inv_two  <= i_cfg_data;
                    dpsh_pkg::CFG_MODULUS_ONE:  r_mod_one  <= i_cfg_data;
                    dpsh_pkg::CFG_MODULUS_TWO:  r_mod_two  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (lane_cmd.start && !is_query) begin
                r_len <= {1'b0, app_pos} + 1'b1;
            end
            if (r_state == dpsh_pkg::TS_OUT && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_query      <= is_query;
            r_res_h1     <= '0;
            r_res_h2     <= '0;
            r_res_status <= full_fail  ? dpsh_pkg::STATUS_FULL
                          : range_fail ? dpsh_pkg::STATUS_RANGE
                          : dpsh_pkg::STATUS_OK;
        end
        // appends keep the zero hashes loaded at accept
        if (r_state == dpsh_pkg::TS_RUN && rsp_one.done && r_query) begin
            r_res_h1 <= rsp_one.hash;
            r_res_h2 <= rsp_two.hash;
        end
        if (r_state == dpsh_pkg::TS_OUT && out_free) begin
            r_o_h1     <= r_res_h1;
            r_o_h2     <= r_res_h2;
            r_o_status <= r_res_status;
        end
    end

    dpsh_lane u_lane_one (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (lane_cmd),
        .i_base     (r_base_one),
        .i_inv_base (r_inv_one),
        .i_modulus  (r_mod_one),
        .o_rsp      (rsp_one)
    );

    dpsh_lane u_lane_two (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (lane_cmd),
        .i_base     (r_base_two),
        .i_inv_base (r_inv_two),
        .i_modulus  (r_mod_two),
        .o_rsp      (rsp_two)
    );

    assign o_valid       = r_o_valid;
    assign o_hash_first  = r_o_h1;
    assign o_hash_second = r_o_h2;
    assign o_status      = r_o_status;

    // both lanes run the same fixed schedule
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_one.done == rsp_two.done)
        else $error("hash lanes out of step");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= dpsh_pkg::LEN_W'(dpsh_pkg::MAX_LEN))
        else $error("string length beyond capacity");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && (r_o_status != dpsh_pkg::STATUS_OK)
        |-> (r_o_h1 == '0) && (r_o_h2 == '0))
        else $error("failed item carries a nonzero hash");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && full_fail |=> (r_len == $past(r_len)) && (r_state == dpsh_pkg::TS_OUT))
        else $error("append to a full string changed state");

    a_lane_only_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_one.done |-> (r_state == dpsh_pkg::TS_RUN))
        else $error("lane finished outside a run");

endmodule
